// ===== rtl/core/ssru_pkg.sv =====
package ssru_pkg;

  // Sketch geometry
  localparam int unsigned NUM_REGS    = 256;
  localparam int unsigned ADDR_W      = $clog2(NUM_REGS);
  localparam int unsigned CNT_W       = $clog2(NUM_REGS + 1);
  localparam int unsigned MAX_BITS    = 8;
  localparam int unsigned REG_W       = MAX_BITS;

  // Field and arithmetic widths
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned LEVEL_W  = 32;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned SHIFT_W  = 32;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CAND_W   = OFFSET_W + 2;   // signed level - offset
  localparam int unsigned EXC_W    = CAND_W - 1;     // non-negative part of a candidate

  localparam logic [OFFSET_W-1:0] OFFSET_TOP     = 32'h7FFF_FFFF;
  localparam logic [CFG_W-1:0]    RESET_REG_BITS = 4'd4;

  // Configuration port
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned PADDR_W  = 3;
  localparam logic        REG_IDX_REG_BITS = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0]          register_index;
    logic signed [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic                       updated;
    logic                       rebased;
    logic [SHIFT_W-1:0]         shift_amount;
    logic [REG_W-1:0]           register_value;
    logic signed [OFFSET_W-1:0] current_offset;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SWEEP,
    ST_FIX
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic sweep;
    logic fix;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rebase;
    logic sweep_done;
  } status_t;

  // Effective register width: 0 acts as 1, above MAX_BITS acts as MAX_BITS
  function automatic logic [CFG_W-1:0] eff_bits(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] b;
    b = raw;
    if (raw == '0) begin
      b = CFG_W'(1);
    end else if (raw > CFG_W'(MAX_BITS)) begin
      b = CFG_W'(MAX_BITS);
    end
    return b;
  endfunction

  // Register maximum, 2^bits - 1
  function automatic logic [REG_W-1:0] reg_max(input logic [CFG_W-1:0] bits);
    logic [REG_W:0] t;
    t = (REG_W + 1)'(1) << bits;
    return REG_W'(t - (REG_W + 1)'(1));
  endfunction

  // Offset after (re)initialisation, 1 - 2^(bits-1)
  function automatic logic signed [OFFSET_W-1:0] offset_init(input logic [CFG_W-1:0] bits);
    logic signed [OFFSET_W-1:0] t;
    t = 32'sd1 <<< (bits - CFG_W'(1));
    return 32'sd1 - t;
  endfunction

endpackage

// ===== rtl/core/ssru_ram.sv =====
module ssru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ssru_ctrl.sv =====
module ssru_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  ssru_pkg::status_t status_i,
  output ssru_pkg::cmd_t    cmd_o
);

  ssru_pkg::state_e state_q, state_d;
  logic             done_q, done_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssru_pkg::ST_IDLE: begin
        if (start) begin
          state_d = ssru_pkg::ST_EVAL;
        end
      end
      ssru_pkg::ST_EVAL: begin
        state_d = status_i.rebase ? ssru_pkg::ST_SWEEP : ssru_pkg::ST_IDLE;
      end
      ssru_pkg::ST_SWEEP: begin
        if (status_i.sweep_done) begin
          state_d = ssru_pkg::ST_FIX;
        end
      end
      ssru_pkg::ST_FIX: begin
        state_d = ssru_pkg::ST_IDLE;
      end
      default: begin
        state_d = ssru_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    done_d = 1'b0;
    busy   = 1'b1;
    case (state_q)
      ssru_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.accept  = start;
      end
      ssru_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        done_d     = !status_i.rebase;
      end
      ssru_pkg::ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
      end
      ssru_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        done_d    = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssru_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/ssru_dp.sv =====
module ssru_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssru_pkg::cmd_t                cmd_i,
  output ssru_pkg::status_t             status_o,
  input  ssru_pkg::item_t               item_i,
  input  logic                          reinit_i,
  input  logic [ssru_pkg::CFG_W-1:0]    cfg_bits_i,
  output ssru_pkg::result_t             result_o
);

  localparam int unsigned AW = ssru_pkg::ADDR_W;
  localparam int unsigned RW = ssru_pkg::REG_W;
  localparam int unsigned CW = ssru_pkg::CAND_W;
  localparam int unsigned EW = ssru_pkg::EXC_W;
  localparam int unsigned OW = ssru_pkg::OFFSET_W;

  // Item registers
  logic [ssru_pkg::IDX_W-1:0] idx_q;
  logic                       in_range_q, in_range_d;
  logic signed [CW-1:0]       cand_q, cand_d;
  logic [EW-1:0]              excess_q, excess_d;
  logic [RW-1:0]              old_q;
  ssru_pkg::result_t          result_q, result_d;

  // Store state
  logic signed [OW-1:0]                 offset_q, offset_d;
  logic [ssru_pkg::NUM_REGS-1:0]        valid_q, valid_d;

  // Sweep
  logic [ssru_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       wr_pend_q, wr_pend_d;
  logic [AW-1:0]              wr_addr_q;
  logic                       sweep_rd;

  // Memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;

  // Evaluation
  logic [ssru_pkg::CFG_W-1:0] eff;
  logic [RW-1:0]       rmax;
  logic [RW-1:0]       old_val;
  logic [EW-1:0]       cand_mag;
  logic                take, over, store, rebase;
  logic [RW-1:0]       sw_old, sw_new;
  logic signed [CW-1:0] off_sum;
  logic signed [OW-1:0] off_new;

  assign eff  = ssru_pkg::eff_bits(cfg_bits_i);
  assign rmax = ssru_pkg::reg_max(eff);

  ssru_ram #(
    .WIDTH (RW),
    .DEPTH (ssru_pkg::NUM_REGS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Candidate at accept: level - offset, never overflows CW bits
  assign cand_d = {{(CW - ssru_pkg::LEVEL_W){item_i.level[ssru_pkg::LEVEL_W-1]}}, item_i.level}
                - {{(CW - OW){offset_q[OW-1]}}, offset_q};
  assign in_range_d = ({1'b0, item_i.register_index} < (ssru_pkg::IDX_W + 1)'(ssru_pkg::NUM_REGS));

  // Compare against the stored value; entries never written read as zero
  assign old_val  = valid_q[idx_q[AW-1:0]] ? ram_rdata : '0;
  assign cand_mag = cand_q[CW-2:0];
  assign take     = in_range_q && !cand_q[CW-1] && (cand_mag > EW'(old_val));
  assign over     = cand_mag > EW'(rmax);
  assign store    = take && !over;
  assign rebase   = take && over;
  assign excess_d = cand_mag - EW'(rmax);

  // Sweep: lower each entry by the excess, flooring at zero
  assign sweep_rd = cmd_i.sweep && !status_o.sweep_done;
  assign sw_old   = valid_q[wr_addr_q] ? ram_rdata : '0;
  assign sw_new   = (excess_q > EW'(sw_old)) ? '0 : (sw_old - excess_q[RW-1:0]);

  // Offset after rebase, saturating at the top
  assign off_sum = {{(CW - OW){offset_q[OW-1]}}, offset_q} + {1'b0, excess_q};
  assign off_new = (!off_sum[CW-1] && (off_sum[CW-2:0] > {1'b0, ssru_pkg::OFFSET_TOP}))
                 ? ssru_pkg::OFFSET_TOP : off_sum[OW-1:0];

  assign status_o.rebase     = rebase;
  assign status_o.sweep_done = (cnt_q == ssru_pkg::CNT_W'(ssru_pkg::NUM_REGS));

  // Memory port selection, one user per state
  always_comb begin
    ram_raddr = sweep_rd ? cnt_q[AW-1:0] : item_i.register_index[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = cand_q[RW-1:0];
    if (cmd_i.eval && store) begin
      ram_we = 1'b1;
    end else if (cmd_i.fix) begin
      ram_we    = 1'b1;
      ram_wdata = rmax;
    end else if (cmd_i.sweep && wr_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = sw_new;
    end
  end

  // Control state next values
  always_comb begin
    valid_d   = valid_q;
    offset_d  = offset_q;
    cnt_d     = cnt_q;
    wr_pend_d = sweep_rd;
    if (reinit_i) begin
      valid_d  = '0;
      offset_d = ssru_pkg::offset_init(eff);
    end else begin
      if (ram_we) begin
        valid_d[ram_waddr] = 1'b1;
      end
      if (cmd_i.fix) begin
        offset_d = off_new;
      end
    end
    if (cmd_i.eval) begin
      cnt_d = '0;
    end else if (sweep_rd) begin
      cnt_d = cnt_q + ssru_pkg::CNT_W'(1);
    end
  end

  // Result
  always_comb begin
    result_d = result_q;
    if (cmd_i.eval) begin
      result_d.updated        = store;
      result_d.rebased        = 1'b0;
      result_d.shift_amount   = '0;
      result_d.register_value = !in_range_q ? '0 : (store ? cand_q[RW-1:0] : old_val);
      result_d.current_offset = offset_q;
    end else if (cmd_i.fix) begin
      result_d.updated        = (rmax != old_q);
      result_d.rebased        = 1'b1;
      result_d.shift_amount   = excess_q[ssru_pkg::SHIFT_W-1:0];
      result_d.register_value = rmax;
      result_d.current_offset = off_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      offset_q  <= ssru_pkg::offset_init(ssru_pkg::eff_bits(ssru_pkg::RESET_REG_BITS));
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      offset_q  <= offset_d;
      cnt_q     <= cnt_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q      <= item_i.register_index;
      in_range_q <= in_range_d;
      cand_q     <= cand_d;
    end
    if (cmd_i.eval) begin
      excess_q <= excess_d;
      old_q    <= old_val;
    end
    if (sweep_rd) begin
      wr_addr_q <= cnt_q[AW-1:0];
    end
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

// ===== rtl/core/shifted_sketch_register_update.sv =====
// Sketch register update. An item (register index, quantised level) is taken
// when start is high and busy is low; its result appears on result_o for one
// cycle with done_o high and must be taken then. An ordinary item first reads
// the named register from the sketch RAM, then compares and writes back, and
// the next item may be started in the cycle its result is shown. An item that
// overflows the register maximum rebases the sketch: a read-modify-write sweep
// over all NUM_REGS entries of the RAM, then a step that sets the named
// register and the offset.
// Writing reg_bits through the APB port clears the sketch and resets the
// offset at once; it is only to be done while busy is low and no result is
// pending.
module shifted_sketch_register_update (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item channel
  input  logic                            start,
  output logic                            busy,
  input  ssru_pkg::item_t                 item_i,
  // Result channel
  output logic                            done_o,
  output ssru_pkg::result_t               result_o,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssru_pkg::PADDR_W-1:0]    paddr,
  input  logic [ssru_pkg::APB_DW-1:0]     pwdata,
  output logic [ssru_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  logic [ssru_pkg::CFG_W-1:0] reg_bits_q;
  logic [ssru_pkg::CFG_W-1:0] cfg_bits;
  logic                       reg_sel;
  logic                       cfg_wr;
  ssru_pkg::cmd_t             cmd;
  ssru_pkg::status_t          status;

  // Register decode, one word per register
  assign reg_sel = (paddr[ssru_pkg::PADDR_W-1:2] == ssru_pkg::REG_IDX_REG_BITS);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? ssru_pkg::APB_DW'(reg_bits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_bits_q <= ssru_pkg::RESET_REG_BITS;
    end else if (cfg_wr) begin
      reg_bits_q <= pwdata[ssru_pkg::CFG_W-1:0];
    end
  end

  // Width in force; a write takes effect in its own cycle
  assign cfg_bits = cfg_wr ? pwdata[ssru_pkg::CFG_W-1:0] : reg_bits_q;

  ssru_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ssru_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .item_i     (item_i),
    .reinit_i   (cfg_wr),
    .cfg_bits_i (cfg_bits),
    .result_o   (result_o)
  );

endmodule

// ===== tb/sv/shifted_sketch_register_update_tb.sv =====
`timescale 1ns / 1ps

module shifted_sketch_register_update_tb;

  import ssru_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 130;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam longint      OFFSET_CEIL     = 64'sd2147483647;
  localparam longint      LEVEL_FLOOR     = -64'sd2147483648;

  localparam logic [PADDR_W-1:0] ADDR_REG_BITS = PADDR_W'(4 * REG_IDX_REG_BITS);
  localparam logic [PADDR_W-1:0] ADDR_SPARE    = PADDR_W'(4);

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG,
    ROW_CFG_SPARE
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [IDX_W-1:0]          idx;
    logic signed [LEVEL_W-1:0] level;
    logic [APB_DW-1:0]         wdata;
    logic                      typed;
    result_t                   want;
  } row_t;

  // Directed sequence; rows with typed set carry a hand-worked result
  localparam int unsigned N_ROWS = 26;
  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    // reset width 4: offset -7, maximum 15
    '{ROW_ITEM, 8'd0,   -32'sd8, 32'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 8'd0,  -32'sd7}},
    '{ROW_ITEM, 8'd0,   -32'sd7, 32'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 8'd0,  -32'sd7}},
    '{ROW_ITEM, 8'd1,   32'sd0,  32'd0, 1'b1, '{1'b1, 1'b0, 32'd0, 8'd7,  -32'sd7}},
    '{ROW_ITEM, 8'd1,   32'sd0,  32'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 8'd7,  -32'sd7}},
    '{ROW_ITEM, 8'd2,   32'sd8,  32'd0, 1'b1, '{1'b1, 1'b0, 32'd0, 8'd15, -32'sd7}},
    '{ROW_ITEM, 8'd3,   32'sd9,  32'd0, 1'b1, '{1'b1, 1'b1, 32'd1, 8'd15, -32'sd6}},
    '{ROW_ITEM, 8'd1,   -32'sd3, 32'd0, 1'b0, '0},
    // rebase with the named register already at maximum
    '{ROW_ITEM, 8'd3,   32'sd10, 32'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 8'd15, -32'sd5}},
    // extreme levels
    '{ROW_ITEM, 8'd255, 32'sh7FFF_FFFF, 32'd0, 1'b1,
      '{1'b1, 1'b1, 32'h7FFF_FFF5, 8'd15, 32'sh7FFF_FFF0}},
    '{ROW_ITEM, 8'd128, 32'sh8000_0000, 32'd0, 1'b1,
      '{1'b0, 1'b0, 32'd0, 8'd0, 32'sh7FFF_FFF0}},
    '{ROW_ITEM, 8'd255, 32'sh7FFF_FFFF, 32'd0, 1'b1,
      '{1'b0, 1'b0, 32'd0, 8'd15, 32'sh7FFF_FFF0}},
    // width 0 behaves as 1: offset 0, maximum 1
    '{ROW_CFG,  8'd0,   32'sd0,  32'hFFFF_FFF0, 1'b0, '0},
    '{ROW_ITEM, 8'd5,   32'sd1,  32'd0, 1'b1, '{1'b1, 1'b0, 32'd0, 8'd1, 32'sd0}},
    '{ROW_ITEM, 8'd6,   32'sd3,  32'd0, 1'b1, '{1'b1, 1'b1, 32'd2, 8'd1, 32'sd2}},
    '{ROW_ITEM, 8'd5,   32'sd2,  32'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 8'd0, 32'sd2}},
    // width above the top behaves as 8: offset -127, maximum 255
    '{ROW_CFG,  8'd0,   32'sd0,  32'h0000_000F, 1'b0, '0},
    '{ROW_ITEM, 8'd10,  32'sd128, 32'd0, 1'b1, '{1'b1, 1'b0, 32'd0, 8'd255, -32'sd127}},
    '{ROW_ITEM, 8'd11,  -32'sd127, 32'd0, 1'b1, '{1'b0, 1'b0, 32'd0, 8'd0, -32'sd127}},
    '{ROW_ITEM, 8'd10,  32'sd129, 32'd0, 1'b1, '{1'b0, 1'b1, 32'd1, 8'd255, -32'sd126}},
    '{ROW_ITEM, 8'd170, -32'sd100, 32'd0, 1'b0, '0},
    // write to an unmapped register must leave the sketch alone
    '{ROW_CFG_SPARE, 8'd0, 32'sd0, 32'h0000_0001, 1'b0, '0},
    '{ROW_ITEM, 8'd170, -32'sd90, 32'd0, 1'b0, '0},
    '{ROW_CFG,  8'd0,   32'sd0,  32'hA5A5_A5A9, 1'b0, '0},
    '{ROW_ITEM, 8'd85,  32'sd0,  32'd0, 1'b1, '{1'b1, 1'b0, 32'd0, 8'd127, -32'sd127}},
    '{ROW_CFG,  8'd0,   32'sd0,  32'h5A5A_5A51, 1'b0, '0},
    '{ROW_ITEM, 8'd0,   32'sd1,  32'd0, 1'b1, '{1'b1, 1'b0, 32'd0, 8'd1, 32'sd0}}
  };

  // Register widths visited by the random phases
  localparam logic [CFG_W-1:0] PHASE_BITS [8] = '{4'd4, 4'd8, 4'd1, 4'd0,
                                                 4'd15, 4'd3, 4'd6, 4'd2};

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  item_t               item_i;
  logic                done_o;
  result_t             result_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Shadow of the sketch state
  logic [REG_W-1:0]    sketch_q [NUM_REGS];
  longint              offset_q;
  logic [CFG_W-1:0]    bits_raw;

  result_t             pending_results [$];
  result_t             want_res;
  int unsigned         mismatches;
  int unsigned         cycle_count = 0;

  shifted_sketch_register_update dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Register width in use after clamping
  function automatic int unsigned width_in_use();
    int unsigned w;
    w = 32'(bits_raw);
    if (w < 1) w = 1;
    if (w > MAX_BITS) w = MAX_BITS;
    return w;
  endfunction

  function automatic longint sketch_ceiling();
    return (longint'(1) << width_in_use()) - 1;
  endfunction

  function automatic void clear_sketch();
    foreach (sketch_q[j]) sketch_q[j] = '0;
    offset_q = 1 - (longint'(1) << (width_in_use() - 1));
  endfunction

  // Applies one level to the shadow state and returns the result it gives
  function automatic result_t apply_level(item_t it);
    longint           cand;
    longint           ceiling;
    longint           excess;
    logic [REG_W-1:0] prior;
    result_t          r;
    ceiling = sketch_ceiling();
    prior   = sketch_q[it.register_index];
    cand    = longint'($signed(it.level)) - offset_q;
    r       = '0;
    if (cand >= 0 && cand > longint'(prior)) begin
      if (cand > ceiling) begin
        excess = cand - ceiling;
        foreach (sketch_q[j]) begin
          sketch_q[j] = (longint'(sketch_q[j]) >= excess) ?
                        REG_W'(longint'(sketch_q[j]) - excess) : '0;
        end
        offset_q = (offset_q > OFFSET_CEIL - excess) ? OFFSET_CEIL : offset_q + excess;
        sketch_q[it.register_index] = REG_W'(ceiling);
        r.rebased      = 1'b1;
        r.shift_amount = excess[SHIFT_W-1:0];
      end else begin
        sketch_q[it.register_index] = REG_W'(cand);
      end
    end
    r.register_value = sketch_q[it.register_index];
    r.updated        = (sketch_q[it.register_index] != prior);
    r.current_offset = offset_q[OFFSET_W-1:0];
    return r;
  endfunction

  // Random item, mostly levels placed just around the current offset
  function automatic item_t random_item();
    item_t      it;
    longint     ceiling;
    longint     delta;
    longint     lv;
    int unsigned mode;
    ceiling = sketch_ceiling();
    mode    = $urandom_range(0, 99);
    it.register_index = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7)) :
                                               IDX_W'($urandom_range(0, 255));
    if (mode >= 85) begin
      it.register_index = IDX_W'($urandom());
      it.level          = $urandom();
      return it;
    end
    if (mode < 70) begin
      delta = longint'($urandom_range(0, int'(ceiling) + 4)) - 2;
    end else if ($urandom_range(0, 3) == 0) begin
      delta = ceiling + longint'($urandom_range(1, 1 << 20));
    end else begin
      delta = ceiling + longint'($urandom_range(1, 4));
    end
    lv = offset_q + delta;
    if (lv > OFFSET_CEIL) lv = OFFSET_CEIL;
    if (lv < LEVEL_FLOOR) lv = LEVEL_FLOOR;
    it.level = lv[LEVEL_W-1:0];
    return it;
  endfunction

  task automatic note_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // One item transfer; the shadow is stepped at the accepting edge
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t r;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    r = apply_level(it);
    pending_results.push_back(typed ? want : r);
  endtask

  // Random gap on the sender side
  task automatic maybe_idle(input logic allow);
    if (allow && $urandom_range(0, 99) < 13) begin
      start  <= 1'b0;
      item_i <= {IDX_W'($urandom()), $urandom()};
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Quiet the item channel and let every result come back
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  // APB transfer: setup cycle, then access cycle (pready is always high)
  task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                          input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a register, mirror it, then read the width register back
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] wdata);
    logic [APB_DW-1:0] rdata;
    apb_xfer(1'b1, addr, wdata, rdata);
    if (addr == ADDR_REG_BITS) begin
      bits_raw = wdata[CFG_W-1:0];
      clear_sketch();
    end
    @(posedge clk_i);
    apb_xfer(1'b0, ADDR_REG_BITS, $urandom(), rdata);
    if (rdata[CFG_W-1:0] !== bits_raw) begin
      note_fault($sformatf("reg_bits readback: exp %0d got %0d", bits_raw,
                           rdata[CFG_W-1:0]));
    end
  endtask

  // Result checker; results cannot be held off, so every strobe is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("result with none outstanding: %p", result_o));
      end else begin
        want_res = pending_results.pop_front();
        if (result_o.updated        !== want_res.updated        ||
            result_o.rebased        !== want_res.rebased        ||
            result_o.shift_amount   !== want_res.shift_amount   ||
            result_o.register_value !== want_res.register_value ||
            result_o.current_offset !== want_res.current_offset) begin
          note_fault($sformatf({"result mismatch: upd %0b/%0b reb %0b/%0b shift %0d/%0d ",
                                "val %0d/%0d off %0d/%0d (exp/got)"},
                               want_res.updated, result_o.updated,
                               want_res.rebased, result_o.rebased,
                               want_res.shift_amount, result_o.shift_amount,
                               want_res.register_value, result_o.register_value,
                               $signed(want_res.current_offset),
                               $signed(result_o.current_offset)));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    mismatches  = 0;
    rst_ni      = 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    bits_raw    = RESET_REG_BITS;
    clear_sketch();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (DIRECTED_ROWS[i]) begin
      case (DIRECTED_ROWS[i].kind)
        ROW_ITEM: begin
          maybe_idle(1'b1);
          send_item('{DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].level},
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        ROW_CFG: begin
          wait_idle();
          cfg_write(ADDR_REG_BITS, DIRECTED_ROWS[i].wdata);
        end
        default: begin
          wait_idle();
          cfg_write(ADDR_SPARE, DIRECTED_ROWS[i].wdata);
        end
      endcase
    end

    // Random phases, one register width each; a stretch in the middle runs gap-free
    k = 0;
    foreach (PHASE_BITS[p]) begin
      wait_idle();
      cfg_write(ADDR_REG_BITS, {(APB_DW - CFG_W)'($urandom() >> CFG_W), PHASE_BITS[p]});
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        maybe_idle(!(k >= 400 && k < 600));
        send_item(random_item(), 1'b0, '0);
        k++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
